### sv/acic_pkg.sv
// shared types, codes and the data-processing opcode map for the a32 classifier
package acic_pkg;

  // instruction class codes, in decode-table order
  typedef enum logic [5:0] {
    CLS_MLA     = 6'd0,  CLS_MUL     = 6'd1,  CLS_UMULL   = 6'd2,  CLS_UMLAL   = 6'd3,
    CLS_SMULL   = 6'd4,  CLS_SMLAL   = 6'd5,  CLS_SWP     = 6'd6,  CLS_BX      = 6'd7,
    CLS_BLX     = 6'd8,  CLS_LDRH    = 6'd9,  CLS_LDRSB   = 6'd10, CLS_LDRSH   = 6'd11,
    CLS_STRH    = 6'd12, CLS_LDRD    = 6'd13, CLS_STRD    = 6'd14, CLS_NOP     = 6'd15,
    CLS_MRS     = 6'd16, CLS_MSR     = 6'd17, CLS_AND     = 6'd18, CLS_EOR     = 6'd19,
    CLS_SUB     = 6'd20, CLS_RSB     = 6'd21, CLS_ADD     = 6'd22, CLS_ADC     = 6'd23,
    CLS_SBC     = 6'd24, CLS_RSC     = 6'd25, CLS_MOVW    = 6'd26, CLS_TST     = 6'd27,
    CLS_TEQ     = 6'd28, CLS_MOVT    = 6'd29, CLS_CMP     = 6'd30, CLS_CMN     = 6'd31,
    CLS_ORR     = 6'd32, CLS_MOV     = 6'd33, CLS_BIC     = 6'd34, CLS_MVN     = 6'd35,
    CLS_UDIV    = 6'd36, CLS_SDIV    = 6'd37, CLS_BFC     = 6'd38, CLS_BFI     = 6'd39,
    CLS_UXTB16  = 6'd40, CLS_UXTAB16 = 6'd41, CLS_UXTB    = 6'd42, CLS_UXTAB   = 6'd43,
    CLS_UXTH    = 6'd44, CLS_UXTAH   = 6'd45, CLS_LDRB    = 6'd46, CLS_LDR     = 6'd47,
    CLS_STRB    = 6'd48, CLS_STR     = 6'd49, CLS_LDM     = 6'd50, CLS_STM     = 6'd51,
    CLS_B       = 6'd52, CLS_BL      = 6'd53, CLS_MRC     = 6'd54, CLS_MCR     = 6'd55,
    CLS_SWI     = 6'd56, CLS_NONE    = 6'd57
  } instr_class_e;

  // diagnostic codes
  typedef enum logic [2:0] {
    DIAG_NONE    = 3'd0,
    DIAG_UNDEF   = 3'd1,
    DIAG_COPROC  = 3'd2,
    DIAG_MSRMASK = 3'd3,
    DIAG_BLCOND  = 3'd4
  } diag_e;

  // one decode result
  typedef struct packed {
    instr_class_e cls;
    diag_e        diag;
  } dec_t;

  // data-processing opcode to class
  function automatic instr_class_e dp_op_class(input logic [3:0] op);
    instr_class_e res;
    case (op)
      4'h0:    res = CLS_AND;
      4'h1:    res = CLS_EOR;
      4'h2:    res = CLS_SUB;
      4'h3:    res = CLS_RSB;
      4'h4:    res = CLS_ADD;
      4'h5:    res = CLS_ADC;
      4'h6:    res = CLS_SBC;
      4'h7:    res = CLS_RSC;
      4'h8:    res = CLS_TST;
      4'h9:    res = CLS_TEQ;
      4'hA:    res = CLS_CMP;
      4'hB:    res = CLS_CMN;
      4'hC:    res = CLS_ORR;
      4'hD:    res = CLS_MOV;
      4'hE:    res = CLS_BIC;
      default: res = CLS_MVN;
    endcase
    return res;
  endfunction

endpackage

### sv/acic_decode.sv
// combinational masked-compare decoder for one a32 instruction word
module acic_decode (
  input  logic [31:0]   instr_i,
  output acic_pkg::dec_t dec_o
);

  // group 0 compare masks and patterns
  localparam logic [31:0] MulMask    = 32'h0FC000F0;
  localparam logic [31:0] MulPat     = 32'h00000090;
  localparam logic [31:0] MullMask   = 32'h0F8000F0;
  localparam logic [31:0] MullPat    = 32'h00800090;
  localparam logic [31:0] SwpMask    = 32'h0FB00FF0;
  localparam logic [31:0] SwpPat     = 32'h01000090;
  localparam logic [31:0] BxMask     = 32'h0FFFFFF0;
  localparam logic [31:0] BxPat      = 32'h012FFF10;
  localparam logic [31:0] BlxPat     = 32'h012FFF30;
  localparam logic [31:0] HwRegMask  = 32'h0E400F90;
  localparam logic [31:0] HwRegPat   = 32'h00000090;
  localparam logic [31:0] DwMask     = 32'h0E0000F0;
  localparam logic [31:0] LdrdPat    = 32'h000000D0;
  localparam logic [31:0] StrdPat    = 32'h000000F0;
  localparam logic [31:0] HwImmMask  = 32'h0E400090;
  localparam logic [31:0] HwImmPat   = 32'h00400090;
  localparam logic [31:0] NopMask    = 32'h0FFFFFFF;
  localparam logic [31:0] NopPat     = 32'h0320F000;
  localparam logic [31:0] MrsMask    = 32'h0FBF0FFF;
  localparam logic [31:0] MrsPat     = 32'h010F0000;
  localparam logic [31:0] MsrRegMask = 32'h0FBFFFF0;
  localparam logic [31:0] MsrRegPat  = 32'h0129F000;
  localparam logic [31:0] MsrMask    = 32'h0DB0F000;
  localparam logic [31:0] MsrPat     = 32'h0120F000;
  // group 1
  localparam logic [31:0] MediaMask  = 32'h0E000010;
  localparam logic [31:0] MediaPat   = 32'h06000010;
  localparam logic [31:0] DivMask    = 32'h0FD0F0F0;
  localparam logic [31:0] DivPat     = 32'h0710F010;
  localparam logic [31:0] BfMask     = 32'h0FE00070;
  localparam logic [31:0] BfPat      = 32'h07C00010;
  localparam logic [31:0] UxtMask    = 32'h0FC000F0;
  localparam logic [31:0] UxtPat     = 32'h06C00070;
  // group 2 and 3
  localparam logic [31:0] BlkMask    = 32'h0E000000;
  localparam logic [31:0] BlkPat     = 32'h08000000;
  localparam logic [31:0] BrMask     = 32'h0F000000;
  localparam logic [31:0] BPat       = 32'h0A000000;
  localparam logic [31:0] BlPat      = 32'h0B000000;
  localparam logic [31:0] CpDtPat    = 32'h0C000000;
  localparam logic [31:0] CpMask     = 32'h0F000010;
  localparam logic [31:0] CpDoPat    = 32'h0E000000;
  localparam logic [31:0] CpRtPat    = 32'h0E000010;

  // halfword load/store by l bit and bits 6:5
  function automatic acic_pkg::dec_t halfword_dec(input logic [31:0] w);
    acic_pkg::dec_t r;
    r.diag = acic_pkg::DIAG_NONE;
    r.cls  = acic_pkg::CLS_NONE;
    if (w[20]) begin
      case (w[6:5])
        2'd1:    r.cls = acic_pkg::CLS_LDRH;
        2'd2:    r.cls = acic_pkg::CLS_LDRSB;
        2'd3:    r.cls = acic_pkg::CLS_LDRSH;
        default: r.diag = acic_pkg::DIAG_UNDEF;
      endcase
    end else if (w[5]) begin
      r.cls = acic_pkg::CLS_STRH;
    end else begin
      r.diag = acic_pkg::DIAG_UNDEF;
    end
    return r;
  endfunction

  logic [31:0]    w;
  acic_pkg::dec_t g0, g1, g2, g3;

  assign w = instr_i;

  // group 0: multiplies, misc, halfword transfers, data processing
  always_comb begin
    g0.diag = acic_pkg::DIAG_NONE;
    g0.cls  = acic_pkg::CLS_NONE;
    if ((w & MulMask) == MulPat) begin
      g0.cls = w[21] ? acic_pkg::CLS_MLA : acic_pkg::CLS_MUL;
    end else if ((w & MullMask) == MullPat) begin
      g0.cls = acic_pkg::instr_class_e'(6'(acic_pkg::CLS_UMULL) + {4'b0000, w[22:21]});
    end else if ((w & SwpMask) == SwpPat) begin
      g0.cls = acic_pkg::CLS_SWP;
    end else if ((w & BxMask) == BxPat) begin
      g0.cls = acic_pkg::CLS_BX;
    end else if ((w & BxMask) == BlxPat) begin
      g0.cls = acic_pkg::CLS_BLX;
    end else if ((w & HwRegMask) == HwRegPat) begin
      g0 = halfword_dec(w);
    end else if ((w & DwMask) == LdrdPat) begin
      g0.cls = acic_pkg::CLS_LDRD;
    end else if ((w & DwMask) == StrdPat) begin
      g0.cls = acic_pkg::CLS_STRD;
    end else if ((w & HwImmMask) == HwImmPat) begin
      g0 = halfword_dec(w);
    end else if ((w & NopMask) == NopPat) begin
      g0.cls = acic_pkg::CLS_NOP;
    end else if ((w & MrsMask) == MrsPat) begin
      g0.cls = acic_pkg::CLS_MRS;
    end else if ((w & MsrRegMask) == MsrRegPat) begin
      g0.cls = acic_pkg::CLS_MSR;
    end else if ((w & MsrMask) == MsrPat) begin
      g0.cls = acic_pkg::CLS_MSR;
      if (w[19:16] != 4'b1000) begin
        g0.diag = acic_pkg::DIAG_MSRMASK;
      end
    end else if (w[25] && !w[20] && w[24:21] == 4'h8) begin
      g0.cls = acic_pkg::CLS_MOVW;
    end else if (w[25] && !w[20] && w[24:21] == 4'hA) begin
      g0.cls = acic_pkg::CLS_MOVT;
    end else begin
      g0.cls = acic_pkg::dp_op_class(w[24:21]);
    end
  end

  // group 1: media space and single loads/stores
  always_comb begin
    g1.diag = acic_pkg::DIAG_NONE;
    g1.cls  = acic_pkg::CLS_NONE;
    if ((w & MediaMask) == MediaPat) begin
      if ((w & DivMask) == DivPat) begin
        g1.cls = w[21] ? acic_pkg::CLS_UDIV : acic_pkg::CLS_SDIV;
      end else if ((w & BfMask) == BfPat) begin
        g1.cls = (w[3:0] == 4'hF) ? acic_pkg::CLS_BFC : acic_pkg::CLS_BFI;
      end else if ((w & UxtMask) == UxtPat && w[21:20] != 2'b01) begin
        case (w[21:20])
          2'd0:    g1.cls = (w[19:16] == 4'hF) ? acic_pkg::CLS_UXTB16
                                               : acic_pkg::CLS_UXTAB16;
          2'd2:    g1.cls = (w[19:16] == 4'hF) ? acic_pkg::CLS_UXTB
                                               : acic_pkg::CLS_UXTAB;
          default: g1.cls = (w[19:16] == 4'hF) ? acic_pkg::CLS_UXTH
                                               : acic_pkg::CLS_UXTAH;
        endcase
      end else begin
        g1.diag = acic_pkg::DIAG_UNDEF;
      end
    end else if (w[20]) begin
      g1.cls = w[22] ? acic_pkg::CLS_LDRB : acic_pkg::CLS_LDR;
    end else begin
      g1.cls = w[22] ? acic_pkg::CLS_STRB : acic_pkg::CLS_STR;
    end
  end

  // group 2: block transfers and branches
  always_comb begin
    g2.diag = acic_pkg::DIAG_NONE;
    g2.cls  = acic_pkg::CLS_NONE;
    if ((w & BlkMask) == BlkPat) begin
      g2.cls = w[20] ? acic_pkg::CLS_LDM : acic_pkg::CLS_STM;
    end else if ((w & BrMask) == BPat) begin
      g2.cls = acic_pkg::CLS_B;
    end else if ((w & BrMask) == BlPat) begin
      g2.cls = acic_pkg::CLS_BL;
      if (w[31:28] == 4'hF) begin
        g2.diag = acic_pkg::DIAG_BLCOND;
      end
    end else begin
      g2.diag = acic_pkg::DIAG_UNDEF;
    end
  end

  // group 3: coprocessor and software interrupt
  always_comb begin
    g3.diag = acic_pkg::DIAG_NONE;
    g3.cls  = acic_pkg::CLS_NONE;
    if ((w & BlkMask) == CpDtPat || (w & CpMask) == CpDoPat) begin
      g3.diag = acic_pkg::DIAG_COPROC;
    end else if ((w & CpMask) == CpRtPat) begin
      g3.cls = w[20] ? acic_pkg::CLS_MRC : acic_pkg::CLS_MCR;
    end else begin
      g3.cls = acic_pkg::CLS_SWI;
    end
  end

  // group select on bits 27:26
  always_comb begin
    case (w[27:26])
      2'd0:    dec_o = g0;
      2'd1:    dec_o = g1;
      2'd2:    dec_o = g2;
      default: dec_o = g3;
    endcase
  end

endmodule

### sv/arm_a32_instruction_classifier.sv
// top level: input register, decoder and result register of the a32 classifier
//
// channel  direction  handshake                         payload
// instr    in         instr_valid_i / instr_ready_o     instr_i[31:0]
// result   out        result_valid_o / result_ready_i   instr_class_o[5:0], diagnostic_o[2:0]
//
// one instruction per cycle sustained while result_ready_i stays high; each transfer's result
// passes the input register, then is decoded into the result register
// both stages advance together; a full pipe stalls only while result_ready_i is low
// rst_ni clears the stage valid bits; payload registers are not reset
module arm_a32_instruction_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        instr_valid_i,
  output logic        instr_ready_o,
  input  logic [31:0] instr_i,
  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic [5:0]  instr_class_o,
  output logic [2:0]  diagnostic_o
);

  logic           s1_valid_q, s1_valid_d;
  logic [31:0]    instr_q;
  logic           s2_valid_q, s2_valid_d;
  acic_pkg::dec_t dec_q, dec_d;
  logic           s2_load, s1_load;

  // pipeline flow control
  assign s2_load       = !s2_valid_q || result_ready_i;
  assign instr_ready_o = !s1_valid_q || s2_load;
  assign s1_load       = instr_valid_i && instr_ready_o;
  assign s1_valid_d    = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_q);
  assign s2_valid_d    = s2_load ? s1_valid_q : s2_valid_q;

  // decode of the held word
  acic_decode u_decode (
    .instr_i (instr_q),
    .dec_o   (dec_d)
  );

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      instr_q <= instr_i;
    end
    if (s2_load && s1_valid_q) begin
      dec_q <= dec_d;
    end
  end

  assign result_valid_o = s2_valid_q;
  assign instr_class_o  = dec_q.cls;
  assign diagnostic_o   = dec_q.diag;

  // an undefined or coprocessor diagnostic never carries a class
  a_diag_no_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (diagnostic_o == acic_pkg::DIAG_UNDEF ||
                       diagnostic_o == acic_pkg::DIAG_COPROC)
    |-> instr_class_o == acic_pkg::CLS_NONE)
    else $error("undefined/coprocessor diagnostic with a class");

  // msr mask diagnostic only on msr, bl condition only on bl
  a_diag_class_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o
    |-> (diagnostic_o != acic_pkg::DIAG_MSRMASK || instr_class_o == acic_pkg::CLS_MSR) &&
        (diagnostic_o != acic_pkg::DIAG_BLCOND || instr_class_o == acic_pkg::CLS_BL))
    else $error("diagnostic does not match class");

  // a full, stalled pipe takes no transfer
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_valid_q && !result_ready_i |-> !instr_ready_o)
    else $error("transfer accepted into full pipe");

  // an accepted word reaches the result stage on the next advance
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_load |=> s2_valid_q)
    else $error("result lost between stages");

  // class code stays in range
  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> instr_class_o <= 6'(acic_pkg::CLS_NONE))
    else $error("class code out of range");

endmodule

### dv/testbench.sv
// self-checking testbench for the a32 instruction classifier
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RANDOM_PER_PHASE = 434;
  localparam int unsigned STALL_LIMIT      = 1000;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned HOLD_AFTER       = 700;
  localparam int unsigned HOLD_CYCLES      = 64;
  localparam int unsigned NUM_DIRECTED     = 25;
  localparam int unsigned NUM_TEMPLATES    = 26;

  // one directed row; cls and diag only count when typed is set
  typedef struct packed {
    logic [31:0]            word;
    logic                   typed;
    acic_pkg::instr_class_e cls;
    acic_pkg::diag_e        diag;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{32'h00000000, 1'b1, acic_pkg::CLS_AND,  acic_pkg::DIAG_NONE},    // all zeros
    '{32'hFFFFFFFF, 1'b1, acic_pkg::CLS_SWI,  acic_pkg::DIAG_NONE},    // all ones
    '{32'hE0200091, 1'b0, acic_pkg::CLS_NONE, acic_pkg::DIAG_NONE},    // mla
    '{32'hE1000091, 1'b0, acic_pkg::CLS_NONE, acic_pkg::DIAG_NONE},    // swp
    '{32'hE12FFF1E, 1'b0, acic_pkg::CLS_NONE, acic_pkg::DIAG_NONE},    // bx lr
    '{32'hE1100090, 1'b1, acic_pkg::CLS_NONE, acic_pkg::DIAG_UNDEF},   // halfword load, 6:5 zero
    '{32'hE10000D0, 1'b1, acic_pkg::CLS_NONE, acic_pkg::DIAG_UNDEF},   // halfword store, bit 5 zero
    '{32'hE1C000B0, 1'b0, acic_pkg::CLS_NONE, acic_pkg::DIAG_NONE},    // strh immediate
    '{32'hE320F000, 1'b0, acic_pkg::CLS_NONE, acic_pkg::DIAG_NONE},    // nop
    '{32'hE10F0000, 1'b0, acic_pkg::CLS_NONE, acic_pkg::DIAG_NONE},    // mrs
    '{32'hE129F00E, 1'b0, acic_pkg::CLS_NONE, acic_pkg::DIAG_NONE},    // msr register, good mask
    '{32'hE324F0FF, 1'b1, acic_pkg::CLS_MSR, acic_pkg::DIAG_MSRMASK},  // msr immediate, bad mask
    '{32'hE3412345, 1'b0, acic_pkg::CLS_NONE, acic_pkg::DIAG_NONE},    // movt
    '{32'hE730F011, 1'b0, acic_pkg::CLS_NONE, acic_pkg::DIAG_NONE},    // udiv
    '{32'hE7C0001F, 1'b0, acic_pkg::CLS_NONE, acic_pkg::DIAG_NONE},    // bfc
    '{32'hE6EF0070, 1'b0, acic_pkg::CLS_NONE, acic_pkg::DIAG_NONE},    // uxtb
    '{32'hE6000010, 1'b1, acic_pkg::CLS_NONE, acic_pkg::DIAG_UNDEF},   // other media space
    '{32'hE6DF0070, 1'b1, acic_pkg::CLS_NONE, acic_pkg::DIAG_UNDEF},   // extend form, 21:20 = 01
    '{32'hE5912000, 1'b0, acic_pkg::CLS_NONE, acic_pkg::DIAG_NONE},    // ldr
    '{32'hE8BD8000, 1'b0, acic_pkg::CLS_NONE, acic_pkg::DIAG_NONE},    // ldm
    '{32'hEB000000, 1'b0, acic_pkg::CLS_NONE, acic_pkg::DIAG_NONE},    // bl
    '{32'hFB000000, 1'b1, acic_pkg::CLS_BL,   acic_pkg::DIAG_BLCOND},  // bl with condition 0xf
    '{32'hED900A00, 1'b1, acic_pkg::CLS_NONE, acic_pkg::DIAG_COPROC},  // coprocessor data transfer
    '{32'hEE000A00, 1'b1, acic_pkg::CLS_NONE, acic_pkg::DIAG_COPROC},  // coprocessor data operation
    '{32'hEE100F10, 1'b0, acic_pkg::CLS_NONE, acic_pkg::DIAG_NONE}     // mrc
  };

  // encoding templates: fixed bits under mask, the rest random
  localparam logic [31:0] TPL_MASK [NUM_TEMPLATES] = '{
    32'h0FC000F0, 32'h0F8000F0, 32'h0FB00FF0, 32'h0FFFFFF0, 32'h0FFFFFF0,
    32'h0E400F90, 32'h0E400090, 32'h0E0000D0, 32'h0FFFFFFF, 32'h0FBF0FFF,
    32'h0FBFFFF0, 32'h0DB0F000, 32'h0E000010, 32'h0E000000, 32'h0FD0F0F0,
    32'h0FE00070, 32'h0FC000F0, 32'h0E000010, 32'h0E000000, 32'h0E000010,
    32'h0E000000, 32'h0E000000, 32'h0E000000, 32'h0F000010, 32'h0F000010,
    32'h0F000000
  };
  localparam logic [31:0] TPL_BITS [NUM_TEMPLATES] = '{
    32'h00000090, 32'h00800090, 32'h01000090, 32'h012FFF10, 32'h012FFF30,
    32'h00000090, 32'h00400090, 32'h000000D0, 32'h0320F000, 32'h010F0000,
    32'h0129F000, 32'h0120F000, 32'h00000000, 32'h02000000, 32'h0710F010,
    32'h07C00010, 32'h06C00070, 32'h06000010, 32'h04000000, 32'h06000000,
    32'h08000000, 32'h0A000000, 32'h0C000000, 32'h0E000000, 32'h0E000010,
    32'h0F000000
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        instr_valid_i;
  logic        instr_ready_o;
  logic [31:0] instr_i;
  logic        result_valid_o;
  logic        result_ready_i;
  logic [5:0]  instr_class_o;
  logic [2:0]  diagnostic_o;

  acic_pkg::dec_t pending_dec [$];
  acic_pkg::dec_t offered_dec;
  acic_pkg::dec_t oldest_dec;
  int unsigned    src_idle_pct;
  int unsigned    sink_idle_pct;
  int unsigned    results_seen   = 0;
  int unsigned    stall_cycles   = 0;
  int unsigned    mismatch_count = 0;
  bit             hold_done      = 1'b0;

  arm_a32_instruction_classifier u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .instr_valid_i  (instr_valid_i),
    .instr_ready_o  (instr_ready_o),
    .instr_i        (instr_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .instr_class_o  (instr_class_o),
    .diagnostic_o   (diagnostic_o)
  );

  always #4 clk_i = ~clk_i;

  // halfword transfer class from the load bit and bits 6:5
  function automatic acic_pkg::dec_t halfword_dec(input logic [31:0] w);
    acic_pkg::dec_t d;
    d.cls  = acic_pkg::CLS_NONE;
    d.diag = acic_pkg::DIAG_UNDEF;
    if (w[20]) begin
      case (w[6:5])
        2'b01:   d = '{acic_pkg::CLS_LDRH, acic_pkg::DIAG_NONE};
        2'b10:   d = '{acic_pkg::CLS_LDRSB, acic_pkg::DIAG_NONE};
        2'b11:   d = '{acic_pkg::CLS_LDRSH, acic_pkg::DIAG_NONE};
        default: d = '{acic_pkg::CLS_NONE, acic_pkg::DIAG_UNDEF};
      endcase
    end else if (w[5]) begin
      d = '{acic_pkg::CLS_STRH, acic_pkg::DIAG_NONE};
    end
    return d;
  endfunction

  // expected class and diagnostic of one instruction word
  function automatic acic_pkg::dec_t decode_a32(input logic [31:0] w);
    acic_pkg::dec_t d;
    logic [3:0]     op;
    d.cls  = acic_pkg::CLS_NONE;
    d.diag = acic_pkg::DIAG_NONE;
    op     = w[24:21];
    case (w[27:26])
      2'b00: begin
        if ((w & 32'h0FC000F0) == 32'h00000090) begin
          d.cls = w[21] ? acic_pkg::CLS_MLA : acic_pkg::CLS_MUL;
        end else if ((w & 32'h0F8000F0) == 32'h00800090) begin
          case (w[22:21])
            2'b00:   d.cls = acic_pkg::CLS_UMULL;
            2'b01:   d.cls = acic_pkg::CLS_UMLAL;
            2'b10:   d.cls = acic_pkg::CLS_SMULL;
            default: d.cls = acic_pkg::CLS_SMLAL;
          endcase
        end else if ((w & 32'h0FB00FF0) == 32'h01000090) begin
          d.cls = acic_pkg::CLS_SWP;
        end else if ((w & 32'h0FFFFFF0) == 32'h012FFF10) begin
          d.cls = acic_pkg::CLS_BX;
        end else if ((w & 32'h0FFFFFF0) == 32'h012FFF30) begin
          d.cls = acic_pkg::CLS_BLX;
        end else if ((w & 32'h0E400F90) == 32'h00000090) begin
          d = halfword_dec(w);
        end else if ((w & 32'h0E0000F0) == 32'h000000D0) begin
          d.cls = acic_pkg::CLS_LDRD;
        end else if ((w & 32'h0E0000F0) == 32'h000000F0) begin
          d.cls = acic_pkg::CLS_STRD;
        end else if ((w & 32'h0E400090) == 32'h00400090) begin
          d = halfword_dec(w);
        end else if ((w & 32'h0FFFFFFF) == 32'h0320F000) begin
          d.cls = acic_pkg::CLS_NOP;
        end else if ((w & 32'h0FBF0FFF) == 32'h010F0000) begin
          d.cls = acic_pkg::CLS_MRS;
        end else if ((w & 32'h0FBFFFF0) == 32'h0129F000) begin
          d.cls = acic_pkg::CLS_MSR;
        end else if ((w & 32'h0DB0F000) == 32'h0120F000) begin
          d.cls = acic_pkg::CLS_MSR;
          if (w[19:16] != 4'h8) d.diag = acic_pkg::DIAG_MSRMASK;
        end else if (w[25] && !w[20] && op == 4'h8) begin
          d.cls = acic_pkg::CLS_MOVW;
        end else if (w[25] && !w[20] && op == 4'hA) begin
          d.cls = acic_pkg::CLS_MOVT;
        end else begin
          case (op)
            4'h0:    d.cls = acic_pkg::CLS_AND;
            4'h1:    d.cls = acic_pkg::CLS_EOR;
            4'h2:    d.cls = acic_pkg::CLS_SUB;
            4'h3:    d.cls = acic_pkg::CLS_RSB;
            4'h4:    d.cls = acic_pkg::CLS_ADD;
            4'h5:    d.cls = acic_pkg::CLS_ADC;
            4'h6:    d.cls = acic_pkg::CLS_SBC;
            4'h7:    d.cls = acic_pkg::CLS_RSC;
            4'h8:    d.cls = acic_pkg::CLS_TST;
            4'h9:    d.cls = acic_pkg::CLS_TEQ;
            4'hA:    d.cls = acic_pkg::CLS_CMP;
            4'hB:    d.cls = acic_pkg::CLS_CMN;
            4'hC:    d.cls = acic_pkg::CLS_ORR;
            4'hD:    d.cls = acic_pkg::CLS_MOV;
            4'hE:    d.cls = acic_pkg::CLS_BIC;
            default: d.cls = acic_pkg::CLS_MVN;
          endcase
        end
      end
      2'b01: begin
        if ((w & 32'h0E000010) == 32'h06000010) begin
          // media space: undefined unless one of the known forms hits
          d.diag = acic_pkg::DIAG_UNDEF;
          if ((w & 32'h0FD0F0F0) == 32'h0710F010) begin
            d = '{(w[21] ? acic_pkg::CLS_UDIV : acic_pkg::CLS_SDIV), acic_pkg::DIAG_NONE};
          end else if ((w & 32'h0FE00070) == 32'h07C00010) begin
            d = '{((w[3:0] == 4'hF) ? acic_pkg::CLS_BFC : acic_pkg::CLS_BFI),
                  acic_pkg::DIAG_NONE};
          end else if ((w & 32'h0FC000F0) == 32'h06C00070) begin
            case (w[21:20])
              2'b00: d = '{((w[19:16] == 4'hF) ? acic_pkg::CLS_UXTB16
                                               : acic_pkg::CLS_UXTAB16),
                           acic_pkg::DIAG_NONE};
              2'b10: d = '{((w[19:16] == 4'hF) ? acic_pkg::CLS_UXTB
                                               : acic_pkg::CLS_UXTAB),
                           acic_pkg::DIAG_NONE};
              2'b11: d = '{((w[19:16] == 4'hF) ? acic_pkg::CLS_UXTH
                                               : acic_pkg::CLS_UXTAH),
                           acic_pkg::DIAG_NONE};
              default: d = '{acic_pkg::CLS_NONE, acic_pkg::DIAG_UNDEF};
            endcase
          end
        end else if (w[20]) begin
          d.cls = w[22] ? acic_pkg::CLS_LDRB : acic_pkg::CLS_LDR;
        end else begin
          d.cls = w[22] ? acic_pkg::CLS_STRB : acic_pkg::CLS_STR;
        end
      end
      2'b10: begin
        if (!w[25]) begin
          d.cls = w[20] ? acic_pkg::CLS_LDM : acic_pkg::CLS_STM;
        end else if (!w[24]) begin
          d.cls = acic_pkg::CLS_B;
        end else begin
          d.cls = acic_pkg::CLS_BL;
          if (w[31:28] == 4'hF) d.diag = acic_pkg::DIAG_BLCOND;
        end
      end
      default: begin
        if (!w[25] || (w[25:24] == 2'b10 && !w[4])) begin
          d.diag = acic_pkg::DIAG_COPROC;
        end else if (w[25:24] == 2'b10) begin
          d.cls = w[20] ? acic_pkg::CLS_MRC : acic_pkg::CLS_MCR;
        end else begin
          d.cls = acic_pkg::CLS_SWI;
        end
      end
    endcase
    return d;
  endfunction

  // offer one word, with random idle cycles ahead of it, until transfer
  task automatic send_word(input logic [31:0] w, input acic_pkg::dec_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      instr_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    instr_valid_i <= 1'b1;
    instr_i       <= w;
    offered_dec    = want;
    @(posedge clk_i);
    while (!instr_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // result checker, expectation capture and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((result_valid_o && result_ready_i) || (instr_valid_i && instr_ready_o)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (result_valid_o && result_ready_i) begin
        results_seen <= results_seen + 1;
        if (pending_dec.size() == 0) begin
          $error("result transfer with nothing expected: class %0d diag %0d",
                 instr_class_o, diagnostic_o);
          mismatch_count++;
        end else begin
          oldest_dec = pending_dec.pop_front();
          if (instr_class_o !== oldest_dec.cls) begin
            $error("instr_class: expected %0d, got %0d", oldest_dec.cls, instr_class_o);
            mismatch_count++;
          end
          if (diagnostic_o !== oldest_dec.diag) begin
            $error("diagnostic: expected %0d, got %0d", oldest_dec.diag, diagnostic_o);
            mismatch_count++;
          end
        end
      end
      if (instr_valid_i && instr_ready_o) begin
        pending_dec.push_back(offered_dec);
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL arm_a32_instruction_classifier");
        $finish;
      end
    end
  end

  // result side: random ready, plus one long hold-off so the pipe backs up
  initial begin
    result_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        result_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      result_ready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // stimulus: directed table, then three random phases
  initial begin : stimulus
    logic [31:0] word;
    int unsigned pick;
    rst_ni         = 1'b0;
    instr_valid_i  = 1'b0;
    instr_i        = '0;
    offered_dec    = '{acic_pkg::CLS_NONE, acic_pkg::DIAG_NONE};
    src_idle_pct   = 14;
    sink_idle_pct  = 54;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows, typed expectation where given
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED_ROWS[i].typed) begin
        send_word(DIRECTED_ROWS[i].word, '{DIRECTED_ROWS[i].cls, DIRECTED_ROWS[i].diag});
      end else begin
        send_word(DIRECTED_ROWS[i].word, decode_a32(DIRECTED_ROWS[i].word));
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 14;
          sink_idle_pct = 54;
        end
        1: begin
          src_idle_pct  = 54;
          sink_idle_pct = 14;
        end
        default: begin
          // sender pause until the pipe has fully drained
          instr_valid_i <= 1'b0;
          while (pending_dec.size() != 0) @(negedge clk_i);
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      repeat (RANDOM_PER_PHASE) begin
        if ($urandom_range(99) < 15) begin
          word = $urandom();
        end else begin
          pick = $urandom_range(NUM_TEMPLATES - 1);
          word = ($urandom() & ~TPL_MASK[pick]) | TPL_BITS[pick];
        end
        send_word(word, decode_a32(word));
      end
    end

    // wait out the last results, then a quiet drain period
    instr_valid_i <= 1'b0;
    while (pending_dec.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS arm_a32_instruction_classifier");
    end else begin
      $display("FAIL arm_a32_instruction_classifier");
    end
    $finish;
  end

endmodule

### arm_a32_instruction_classifier.f
sv/acic_pkg.sv
sv/acic_decode.sv
sv/arm_a32_instruction_classifier.sv
dv/testbench.sv
